[design/led_matrix_scan_dimmer_unit_defines.svh]
// Assertion macros for the LED matrix scan dimmer.
// Used by led_matrix_scan_dimmer_unit.sv; needs nothing else.
`ifndef LED_MATRIX_SCAN_DIMMER_UNIT_DEFINES_SVH
`define LED_MATRIX_SCAN_DIMMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LMSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lmsd_pkg.sv]
// Shared types and constants for the LED matrix scan dimmer.
// No dependencies.
package lmsd_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int LEVELS      = 8;
    localparam int LEVEL_W     = 4;
    localparam int IDX_W       = $clog2(MATRIX_SIZE);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int DEPTH       = MATRIX_SIZE * MATRIX_SIZE;
    localparam int COL_CNT_W   = $clog2(MATRIX_SIZE + 1);
    localparam int NUM_LEVELS  = 2 ** LEVEL_W;

    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] REG_TARGET_ENABLE = 2'd0;

    localparam logic [LEVEL_W-1:0] LEVEL_OFF = LEVEL_W'(LEVELS);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Bit L set when level L divides phase; level 0 never lights.
    function automatic logic [NUM_LEVELS-1:0] lit_mask(input logic [LEVEL_W-1:0] phase);
        logic [NUM_LEVELS-1:0] m;
        m = '0;
        for (int l = 1; l < NUM_LEVELS; l++)
        begin
            for (int k = 1; k < NUM_LEVELS; k++)
            begin
                if (l * k == int'(phase))
                begin
                    m[l] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

[design/led_matrix_scan_dimmer_unit.sv]
// Top level of the LED matrix scan dimmer: pixel level memory, scan sequencer, APB register.
// Depends on lmsd_pkg and led_matrix_scan_dimmer_unit_defines.svh.
//
// A write or clear transaction is taken in one cycle and gives no result; start may be held
// high for one per cycle. A scan tick keeps busy high after it is taken and puts its result
// on row_select_n and column_bits with done high in the cycle that busy falls; no transaction
// is taken while busy is high. The length of a scan comes from the single read port of the
// pixel memory: one column of the scanned row is fetched per cycle and checked against the
// phase in the next cycle. The receiver cannot stall; a result is valid only in its done cycle. The next
// transaction may be started in the same cycle that done is high. No clearing pass is needed
// after reset.

`include "led_matrix_scan_dimmer_unit_defines.svh"

module led_matrix_scan_dimmer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [lmsd_pkg::IDX_W-1:0]         write_row,
    input  logic [lmsd_pkg::IDX_W-1:0]         write_col,
    input  logic [lmsd_pkg::LEVEL_W-1:0]       write_level,
    input  logic [lmsd_pkg::IDX_W-1:0]         target_x,
    input  logic [lmsd_pkg::IDX_W-1:0]         target_y,
    input  logic [lmsd_pkg::LEVEL_W-1:0]       target_level,
    // result channel
    output logic                               done,
    output logic [lmsd_pkg::MATRIX_SIZE-1:0]   row_select_n,
    output logic [lmsd_pkg::MATRIX_SIZE-1:0]   column_bits,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lmsd_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    localparam int LW = lmsd_pkg::LEVEL_W;
    localparam int IW = lmsd_pkg::IDX_W;
    localparam int CW = lmsd_pkg::COL_CNT_W;
    localparam int MS = lmsd_pkg::MATRIX_SIZE;

    state_t                           state_reg, state_next;
    logic [IW-1:0]                    scan_row_reg, scan_row_next;
    logic [LW-1:0]                    phase_reg, phase_next;
    logic [lmsd_pkg::NUM_LEVELS-1:0]  mask_reg, mask_next;
    logic                             tgt_row_hit_reg, tgt_row_hit_next;
    logic [IW-1:0]                    tgt_x_reg, tgt_x_next;
    logic [LW-1:0]                    tgt_level_reg, tgt_level_next;
    logic [CW-1:0]                    col_cnt_reg, col_cnt_next;
    logic                             pend_reg, pend_next;
    logic [IW-1:0]                    col_idx_reg, col_idx_next;
    logic [MS-1:0]                    cols_reg, cols_next;
    logic                             done_reg, done_next;
    logic [lmsd_pkg::DEPTH-1:0]       valid_reg, valid_next;
    logic                             target_enable_reg, target_enable_next;

    // pixel level memory
    logic [LW-1:0]                    mem [lmsd_pkg::DEPTH];
    logic [LW-1:0]                    rd_data_reg;
    logic                             rd_valid_reg;
    logic                             mem_we;
    logic [lmsd_pkg::ADDR_W-1:0]      wr_addr;
    logic                             rd_en;
    logic [lmsd_pkg::ADDR_W-1:0]      rd_addr;

    logic                             accept;
    logic                             cfg_write;
    logic [LW-1:0]                    eval_level;
    logic                             eval_lit;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == lmsd_pkg::REG_TARGET_ENABLE) ?
                       {31'd0, target_enable_reg} : 32'd0;

    assign wr_addr = {write_row, write_col};
    assign mem_we  = accept && (opcode == lmsd_pkg::OP_WRITE);
    // displayed row is the mirror of the scan row
    assign rd_addr = {~scan_row_reg, col_cnt_reg[IW-1:0]};
    assign rd_en   = (state_reg == S_SCAN) && (col_cnt_reg < CW'(MS));

    // shared compare: pick the level of one column and test it against the phase mask
    always_comb
    begin
        if (tgt_row_hit_reg && (tgt_x_reg == col_idx_reg))
        begin
            eval_level = tgt_level_reg;
        end
        else if (rd_valid_reg)
        begin
            eval_level = rd_data_reg;
        end
        else
        begin
            eval_level = lmsd_pkg::LEVEL_OFF;
        end
        eval_lit = mask_reg[eval_level];
    end

    always_comb
    begin
        state_next         = state_reg;
        scan_row_next      = scan_row_reg;
        phase_next         = phase_reg;
        mask_next          = mask_reg;
        tgt_row_hit_next   = tgt_row_hit_reg;
        tgt_x_next         = tgt_x_reg;
        tgt_level_next     = tgt_level_reg;
        col_cnt_next       = col_cnt_reg;
        pend_next          = 1'b0;
        col_idx_next       = col_idx_reg;
        cols_next          = cols_reg;
        done_next          = 1'b0;
        valid_next         = valid_reg;
        target_enable_next = target_enable_reg;

        if (cfg_write && (paddr == lmsd_pkg::REG_TARGET_ENABLE))
        begin
            target_enable_next = pwdata[0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        lmsd_pkg::OP_TICK:
                        begin
                            scan_row_next = scan_row_reg + 1'b1;
                            if (phase_reg >= LW'(lmsd_pkg::LEVELS - 1))
                            begin
                                phase_next = LW'(1);
                            end
                            else
                            begin
                                phase_next = phase_reg + 1'b1;
                            end
                            mask_next        = lmsd_pkg::lit_mask(phase_next);
                            tgt_row_hit_next = target_enable_reg &&
                                               (scan_row_next == ~target_y);
                            tgt_x_next       = target_x;
                            tgt_level_next   = target_level;
                            col_cnt_next     = '0;
                            cols_next        = '0;
                            state_next       = S_SCAN;
                        end
                        lmsd_pkg::OP_WRITE:
                        begin
                            valid_next[wr_addr] = 1'b1;
                        end
                        lmsd_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    pend_next    = 1'b1;
                    col_idx_next = col_cnt_reg[IW-1:0];
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    // column 0 is shifted in first and ends at the top bit
                    cols_next = {cols_reg[MS-2:0], eval_lit};
                    if (col_idx_reg == IW'(MS - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            scan_row_reg      <= '0;
            phase_reg         <= '0;
            mask_reg          <= '0;
            tgt_row_hit_reg   <= 1'b0;
            tgt_x_reg         <= '0;
            tgt_level_reg     <= '0;
            col_cnt_reg       <= '0;
            pend_reg          <= 1'b0;
            col_idx_reg       <= '0;
            cols_reg          <= '0;
            done_reg          <= 1'b0;
            valid_reg         <= '0;
            target_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            scan_row_reg      <= scan_row_next;
            phase_reg         <= phase_next;
            mask_reg          <= mask_next;
            tgt_row_hit_reg   <= tgt_row_hit_next;
            tgt_x_reg         <= tgt_x_next;
            tgt_level_reg     <= tgt_level_next;
            col_cnt_reg       <= col_cnt_next;
            pend_reg          <= pend_next;
            col_idx_reg       <= col_idx_next;
            cols_reg          <= cols_next;
            done_reg          <= done_next;
            valid_reg         <= valid_next;
            target_enable_reg <= target_enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= write_level;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign column_bits  = cols_reg;
    assign row_select_n = ~(MS'(1) << scan_row_reg);

    `LMSD_ASSERT_NOW(a_done_when_idle, clk, rst_n, done, !busy, "result strobe while scanning")
    `LMSD_ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && (opcode == lmsd_pkg::OP_TICK), busy, "tick did not start a scan")
    `LMSD_ASSERT_NOW(a_row_onecold, clk, rst_n, done, $onehot(~row_select_n), "row select not one-cold")
    `LMSD_ASSERT_NEXT(a_clear_all, clk, rst_n, start && !busy && (opcode == lmsd_pkg::OP_CLEAR), valid_reg == '0, "clear left pixels valid")

endmodule

[dv/tb.sv]
// Self-checking testbench for led_matrix_scan_dimmer_unit: directed and random command traffic.
// Depends on lmsd_pkg and the design sources; predicts every scan result and checks it on done.
`timescale 1ns / 100ps

module tb;

    import lmsd_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         RAND_PHASES  = 4;
    localparam int         PHASE_ITEMS  = 250;

    typedef struct {
        logic [1:0]         op;
        logic [IDX_W-1:0]   write_row;
        logic [IDX_W-1:0]   write_col;
        logic [LEVEL_W-1:0] write_level;
        logic [IDX_W-1:0]   target_x;
        logic [IDX_W-1:0]   target_y;
        logic [LEVEL_W-1:0] target_level;
    } cmd_t;

    typedef struct {
        logic [MATRIX_SIZE-1:0] row_select_n;
        logic [MATRIX_SIZE-1:0] column_bits;
    } scan_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             opcode = OP_TICK;
    logic [IDX_W-1:0]       write_row = '0;
    logic [IDX_W-1:0]       write_col = '0;
    logic [LEVEL_W-1:0]     write_level = '0;
    logic [IDX_W-1:0]       target_x = '0;
    logic [IDX_W-1:0]       target_y = '0;
    logic [LEVEL_W-1:0]     target_level = '0;
    logic                   done;
    logic [MATRIX_SIZE-1:0] row_select_n;
    logic [MATRIX_SIZE-1:0] column_bits;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Shadow state of the scanner
    logic [LEVEL_W-1:0]     level_mem [DEPTH];
    logic [LEVEL_W-1:0]     phase_cnt;
    logic [IDX_W-1:0]       scan_row;
    logic                   target_en;

    cmd_t                   cmd_q[$];
    scan_out_t              scan_expect_q[$];
    cmd_t                   cur_cmd;
    cmd_t                   nxt_cmd;
    scan_out_t              got_exp;
    int                     idle_pct = 0;
    int                     queued_cnt = 0;
    int                     accepted_cnt = 0;
    int                     fail_cnt = 0;

    led_matrix_scan_dimmer_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .write_row    (write_row),
        .write_col    (write_col),
        .write_level  (write_level),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_level (target_level),
        .done         (done),
        .row_select_n (row_select_n),
        .column_bits  (column_bits),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one accepted command to the shadow state; ticks push the expected scan output.
    function automatic void apply_command(input cmd_t c);
        logic [IDX_W-1:0]       shown_row;
        logic [LEVEL_W-1:0]     lvl;
        logic [MATRIX_SIZE-1:0] cols;
        scan_out_t              res;
        cols = '0;
        if (c.op == OP_WRITE)
        begin
            level_mem[{c.write_row, c.write_col}] = c.write_level;
        end
        else if (c.op == OP_CLEAR)
        begin
            foreach (level_mem[i])
                level_mem[i] = LEVEL_OFF;
        end
        else if (c.op == OP_TICK)
        begin
            scan_row  = scan_row + 1'b1;
            phase_cnt = (phase_cnt >= LEVEL_W'(LEVELS - 1)) ? LEVEL_W'(1) : phase_cnt + 1'b1;
            // scan row s shows stored row 7-s
            shown_row = ~scan_row;
            for (int x = 0; x < MATRIX_SIZE; x++)
            begin
                if (target_en && scan_row == ~c.target_y && c.target_x == IDX_W'(x))
                    lvl = c.target_level;
                else
                    lvl = level_mem[{shown_row, IDX_W'(x)}];
                if (lvl != 0 && (int'(phase_cnt) % int'(lvl)) == 0)
                    cols[MATRIX_SIZE-1-x] = 1'b1;
            end
            res.row_select_n = ~(MATRIX_SIZE'(1) << scan_row);
            res.column_bits  = cols;
            scan_expect_q.push_back(res);
        end
    endfunction

    // Command driver: holds a command until start && !busy, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_command(cur_cmd);
                accepted_cnt++;
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt_cmd      = cmd_q.pop_front();
                    cur_cmd      = nxt_cmd;
                    start        <= 1'b1;
                    opcode       <= nxt_cmd.op;
                    write_row    <= nxt_cmd.write_row;
                    write_col    <= nxt_cmd.write_col;
                    write_level  <= nxt_cmd.write_level;
                    target_x     <= nxt_cmd.target_x;
                    target_y     <= nxt_cmd.target_y;
                    target_level <= nxt_cmd.target_level;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (scan_expect_q.size() == 0)
            begin
                $error("unexpected result: row_select_n=%h column_bits=%h",
                       row_select_n, column_bits);
                fail_cnt++;
            end
            else
            begin
                got_exp = scan_expect_q.pop_front();
                if (row_select_n !== got_exp.row_select_n)
                begin
                    $error("row_select_n: expected %h, got %h",
                           got_exp.row_select_n, row_select_n);
                    fail_cnt++;
                end
                if (column_bits !== got_exp.column_bits)
                begin
                    $error("column_bits: expected %h, got %h",
                           got_exp.column_bits, column_bits);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic cmd_t make_cmd(input logic [1:0] op, input int row, input int col,
                                      input int lvl, input int tx, input int ty, input int tl);
        cmd_t c;
        c.op           = op;
        c.write_row    = IDX_W'(row);
        c.write_col    = IDX_W'(col);
        c.write_level  = LEVEL_W'(lvl);
        c.target_x     = IDX_W'(tx);
        c.target_y     = IDX_W'(ty);
        c.target_level = LEVEL_W'(tl);
        return c;
    endfunction

    // Mostly in-range levels, sometimes the full 4-bit range
    function automatic int rand_level();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, LEVELS);
    endfunction

    function automatic cmd_t rand_cmd();
        int         sel;
        logic [1:0] op;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            op = OP_TICK;
        else if (sel < 93)
            op = OP_WRITE;
        else if (sel < 97)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        return make_cmd(op, $urandom_range(0, 7), $urandom_range(0, 7), rand_level(),
                        $urandom_range(0, 7), $urandom_range(0, 7), rand_level());
    endfunction

    task automatic queue_cmd(input cmd_t c);
        cmd_q.push_back(c);
        queued_cnt++;
    endtask

    // Wait until every command is taken and every scan result is back (or the wait limit runs
    // out), then let a trailing write or clear settle.
    task automatic wait_drained();
        int waited;
        waited = 0;
        do @(posedge clk); while (accepted_cnt != queued_cnt);
        while (scan_expect_q.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target_enable(input logic val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TARGET_ENABLE;
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        target_en = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        foreach (level_mem[i])
            level_mem[i] = LEVEL_OFF;
        phase_cnt = '0;
        scan_row  = '0;
        target_en = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners, level extremes, unused opcode, clear, target override
        queue_cmd(make_cmd(OP_TICK,   0, 0, 0,  0, 0, 0));
        queue_cmd(make_cmd(OP_UNUSED, 7, 7, 15, 7, 7, 15));
        queue_cmd(make_cmd(OP_WRITE,  0, 0, 1,  0, 0, 0));
        queue_cmd(make_cmd(OP_WRITE,  7, 7, 0,  7, 7, 15));
        queue_cmd(make_cmd(OP_WRITE,  0, 7, 8,  0, 0, 0));
        queue_cmd(make_cmd(OP_WRITE,  7, 0, 15, 0, 0, 0));
        queue_cmd(make_cmd(OP_WRITE,  3, 4, 2,  0, 0, 0));
        queue_cmd(make_cmd(OP_WRITE,  4, 3, 7,  0, 0, 0));
        for (int i = 0; i < 8; i++)
            queue_cmd(make_cmd(OP_TICK, 0, 0, 0, 7 - i, i, 1));
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_TICK,  0, 0, 0, 0, 0, 0));
        wait_drained();

        write_target_enable(1'b1);
        queue_cmd(make_cmd(OP_WRITE, 5, 5, 1, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            queue_cmd(make_cmd(OP_TICK, 0, 0, 0, i, i, (i % 2 == 0) ? 1 : ((i == 3) ? 0 : 15)));
        wait_drained();

        // The receiver cannot stall, so its stall phase runs with a busy sender.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 0;
                default: idle_pct = 16;
            endcase
            write_target_enable((p % 2 == 0) ? 1'b0 : 1'b1);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_cmd(rand_cmd());
            wait_drained();
        end

        if (scan_expect_q.size() != 0)
        begin
            $error("%0d scan results never arrived", scan_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
